// File: rtl/dmxw_pkg.sv
// ----------------------------------------------------------------------------
// dmxw_pkg
// Shared codes and types of the DMX512 window receiver.
// ----------------------------------------------------------------------------
package dmxw_pkg;

    localparam int CMD_W     = 2;
    localparam int BYTE_W    = 8;
    localparam int SLOT_W    = 10;

    localparam logic [CMD_W-1:0] CMD_BYTE     = 2'd0;
    localparam logic [CMD_W-1:0] CMD_READ_REL = 2'd1;
    localparam logic [CMD_W-1:0] CMD_READ_ABS = 2'd2;

    localparam logic [SLOT_W-1:0] DMX_SLOTS   = 10'd512;
    localparam logic [SLOT_W-1:0] COUNTER_MAX = 10'd1023;

    // operation passed from the classifier to the executor
    typedef struct packed {
        logic is_write;   // store write (else read request)
        logic hit;        // read lies inside the window
    } op_t;

endpackage

// File: rtl/dmx512_window_receiver.sv
// ----------------------------------------------------------------------------
// dmx512_window_receiver
// DMX512 slot receiver that captures a window of WINDOW slots starting at a
// programmable slot address and answers relative or absolute read requests.
// ----------------------------------------------------------------------------
//  channel   ports                                          direction
//  input     s_valid/s_ready, s_command, s_rx_byte,         in
//            s_frame_error, s_channel
//  result    m_valid/m_ready, m_read_value, m_in_range      out
//  config    cfg_valid/cfg_ready, cfg_data (start_address)  in
//
//  One item per cycle is accepted while s_ready is high; for a read, m_valid
//  rises once its request has passed the queue entry, the store read port
//  and the result register.
//  After reset the slot store is cleared one entry a cycle, all WINDOW
//  entries, while s_ready stays low; cfg writes are taken at any time.
//  A stalled result holds the read stage; the two-entry queue then fills and
//  drops s_ready. Received bytes produce no result.
// ----------------------------------------------------------------------------
module dmx512_window_receiver #(
    parameter int WINDOW = 16
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       s_valid,
    output logic                       s_ready,
    input  logic [dmxw_pkg::CMD_W-1:0]  s_command,
    input  logic [dmxw_pkg::BYTE_W-1:0] s_rx_byte,
    input  logic                       s_frame_error,
    input  logic [dmxw_pkg::SLOT_W-1:0] s_channel,
    output logic                       m_valid,
    input  logic                       m_ready,
    output logic [dmxw_pkg::BYTE_W-1:0] m_read_value,
    output logic                       m_in_range,
    input  logic                       cfg_valid,
    output logic                       cfg_ready,
    input  logic [dmxw_pkg::SLOT_W-1:0] cfg_data
);

    localparam int IDXW   = (WINDOW > 1) ? $clog2(WINDOW) : 1;
    localparam int BW     = dmxw_pkg::BYTE_W;
    localparam int OPW    = $bits(dmxw_pkg::op_t);
    localparam int QW     = OPW + IDXW + BW;
    localparam int QDEPTH = 2;

    logic [dmxw_pkg::SLOT_W-1:0] start_address_reg;
    logic                        push, q_full, q_valid, q_pop, clearing;
    dmxw_pkg::op_t               push_op, q_op;
    logic [IDXW-1:0]             push_index, q_index;
    logic [BW-1:0]               push_data, q_data;
    logic [QW-1:0]               q_head;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            start_address_reg <= dmxw_pkg::SLOT_W'(1);
        end else if (cfg_valid && cfg_ready) begin
            start_address_reg <= cfg_data;
        end
    end

    dmxw_front #(
        .WINDOW (WINDOW),
        .IDXW   (IDXW)
    ) u_front (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .start_address (start_address_reg),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .command       (s_command),
        .rx_byte       (s_rx_byte),
        .frame_error   (s_frame_error),
        .channel       (s_channel),
        .q_full        (q_full),
        .clearing      (clearing),
        .push          (push),
        .push_op       (push_op),
        .push_index    (push_index),
        .push_data     (push_data)
    );

    dmxw_queue #(
        .WIDTH (QW),
        .DEPTH (QDEPTH)
    ) u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push),
        .push_data  ({push_op, push_index, push_data}),
        .full       (q_full),
        .pop        (q_pop),
        .head_valid (q_valid),
        .head_data  (q_head)
    );

    assign {q_op, q_index, q_data} = q_head;

    dmxw_back #(
        .WINDOW (WINDOW),
        .IDXW   (IDXW)
    ) u_back (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .q_valid      (q_valid),
        .q_op         (q_op),
        .q_index      (q_index),
        .q_data       (q_data),
        .q_pop        (q_pop),
        .clearing     (clearing),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_read_value (m_read_value),
        .m_in_range   (m_in_range)
    );

`ifndef SYNTHESIS
    a_miss_reads_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_in_range) |-> (m_read_value == '0))
        else $error("out-of-window result carries a nonzero value");

    a_no_push_when_full: assert property (@(posedge aclk) disable iff (!aresetn)
        push |-> !q_full)
        else $error("operation pushed into a full queue");

    a_queue_empty_while_clearing: assert property (@(posedge aclk) disable iff (!aresetn)
        clearing |-> (!q_valid && !m_valid))
        else $error("work pending during the store clearing pass");
`endif

endmodule

// File: rtl/dmxw_ram.sv
// ----------------------------------------------------------------------------
// dmxw_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module dmxw_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// File: rtl/dmxw_front.sv
// ----------------------------------------------------------------------------
// dmxw_front
// Accepts items, tracks the break / start code / data phases and the slot
// counter, and turns window slots into store writes, reads into read ops.
// ----------------------------------------------------------------------------
module dmxw_front #(
    parameter int WINDOW = 16,
    parameter int IDXW   = (WINDOW > 1) ? $clog2(WINDOW) : 1
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic [dmxw_pkg::SLOT_W-1:0] start_address,
    input  logic                       s_valid,
    output logic                       s_ready,
    input  logic [dmxw_pkg::CMD_W-1:0]  command,
    input  logic [dmxw_pkg::BYTE_W-1:0] rx_byte,
    input  logic                       frame_error,
    input  logic [dmxw_pkg::SLOT_W-1:0] channel,
    input  logic                       q_full,
    input  logic                       clearing,
    output logic                       push,
    output dmxw_pkg::op_t              push_op,
    output logic [IDXW-1:0]            push_index,
    output logic [dmxw_pkg::BYTE_W-1:0] push_data
);

    localparam logic [1:0] PH_IDLE  = 2'd0;
    localparam logic [1:0] PH_BREAK = 2'd1;
    localparam logic [1:0] PH_DATA  = 2'd2;

    localparam int SW = dmxw_pkg::SLOT_W;

    logic [1:0]    phase_reg, phase_next;
    logic [SW-1:0] counter_reg, counter_next;
    logic          accept;
    logic [SW:0]   win_end;
    logic          cnt_in_win;
    logic [SW-1:0] cnt_off;
    logic [SW-1:0] abs_off;
    logic          rel_hit, abs_hit;

    assign s_ready = !q_full && !clearing;
    assign accept  = s_valid && s_ready;

    assign win_end    = {1'b0, start_address} + (SW+1)'(WINDOW);
    assign cnt_in_win = (counter_reg >= start_address) && ({1'b0, counter_reg} < win_end);
    assign cnt_off    = counter_reg - start_address;

    assign rel_hit = {1'b0, channel} < (SW+1)'(WINDOW);
    assign abs_off = channel - start_address;
    assign abs_hit = (channel != '0) && (channel <= dmxw_pkg::DMX_SLOTS) &&
                     (channel >= start_address) && ({1'b0, abs_off} < (SW+1)'(WINDOW));

    always_comb begin
        phase_next   = phase_reg;
        counter_next = counter_reg;
        push         = 1'b0;
        push_op      = '0;
        push_index   = '0;
        push_data    = rx_byte;
        if (accept) begin
            case (command)
                dmxw_pkg::CMD_BYTE: begin
                    if (frame_error) begin
                        phase_next   = PH_BREAK;
                        counter_next = '0;
                    end else if (phase_reg == PH_BREAK) begin
                        if (rx_byte == '0) begin
                            phase_next   = PH_DATA;
                            counter_next = SW'(1);
                        end else begin
                            phase_next = PH_IDLE;
                        end
                    end else if (phase_reg == PH_DATA) begin
                        if (cnt_in_win) begin
                            push             = 1'b1;
                            push_op.is_write = 1'b1;
                            push_index       = IDXW'(cnt_off);
                        end
                        // first slot past the window ends the capture
                        if ({1'b0, counter_reg} >= win_end) begin
                            phase_next = PH_IDLE;
                        end
                        if (counter_reg != dmxw_pkg::COUNTER_MAX) begin
                            counter_next = counter_reg + SW'(1);
                        end
                    end
                end
                dmxw_pkg::CMD_READ_REL: begin
                    push        = 1'b1;
                    push_op.hit = rel_hit;
                    push_index  = IDXW'(channel);
                end
                dmxw_pkg::CMD_READ_ABS: begin
                    push        = 1'b1;
                    push_op.hit = abs_hit;
                    push_index  = IDXW'(abs_off);
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg   <= PH_IDLE;
            counter_reg <= '0;
        end else begin
            phase_reg   <= phase_next;
            counter_reg <= counter_next;
        end
    end

endmodule

// File: rtl/dmxw_queue.sv
// ----------------------------------------------------------------------------
// dmxw_queue
// Small FIFO between the classifier and the executor.
// ----------------------------------------------------------------------------
module dmxw_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2,
    parameter int PW    = $clog2(DEPTH),
    parameter int CW    = $clog2(DEPTH + 1)
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    output logic             full,
    input  logic             pop,
    output logic             head_valid,
    output logic [WIDTH-1:0] head_data
);

    logic [WIDTH-1:0] entry_reg [DEPTH];
    logic [PW-1:0]    wr_ptr_reg, rd_ptr_reg;
    logic [CW-1:0]    count_reg, count_next;
    logic             do_push, do_pop;

    assign full       = count_reg == CW'(DEPTH);
    assign head_valid = count_reg != '0;
    assign head_data  = entry_reg[rd_ptr_reg];
    assign do_push    = push && !full;
    assign do_pop     = pop && head_valid;

    always_comb begin
        count_next = count_reg;
        if (do_push && !do_pop) begin
            count_next = count_reg + CW'(1);
        end else if (do_pop && !do_push) begin
            count_next = count_reg - CW'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            count_reg <= count_next;
            if (do_push) begin
                wr_ptr_reg <= (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + PW'(1);
            end
            if (do_pop) begin
                rd_ptr_reg <= (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + PW'(1);
            end
        end
    end

endmodule

// File: rtl/dmxw_back.sv
// ----------------------------------------------------------------------------
// dmxw_back
// Executes queued operations: clears the slot store after reset, writes
// captured slots, and reads the store for read requests that hit into the
// result register (zero for a miss).
// ----------------------------------------------------------------------------
module dmxw_back #(
    parameter int WINDOW = 16,
    parameter int IDXW   = (WINDOW > 1) ? $clog2(WINDOW) : 1
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       q_valid,
    input  dmxw_pkg::op_t              q_op,
    input  logic [IDXW-1:0]            q_index,
    input  logic [dmxw_pkg::BYTE_W-1:0] q_data,
    output logic                       q_pop,
    output logic                       clearing,
    output logic                       m_valid,
    input  logic                       m_ready,
    output logic [dmxw_pkg::BYTE_W-1:0] m_read_value,
    output logic                       m_in_range
);

    localparam int BW = dmxw_pkg::BYTE_W;

    logic            clearing_reg;
    logic [IDXW-1:0] clr_addr_reg;
    logic            rd_valid_reg, rd_valid_next;
    logic            rd_hit_reg;
    logic            rd_advance;
    logic            m_valid_reg;
    logic [BW-1:0]   m_value_reg;
    logic            m_in_range_reg;
    logic            ram_we, ram_re;
    logic [IDXW-1:0] ram_waddr;
    logic [BW-1:0]   ram_wdata, ram_rdata;

    assign clearing   = clearing_reg;
    assign rd_advance = rd_valid_reg && (!m_valid_reg || m_ready);

    // writes never disturb a pending read; reads wait for a free read stage
    assign q_pop = q_valid && !clearing_reg &&
                   (q_op.is_write || !rd_valid_reg || rd_advance);

    assign ram_we    = clearing_reg || (q_pop && q_op.is_write);
    assign ram_waddr = clearing_reg ? clr_addr_reg : q_index;
    assign ram_wdata = clearing_reg ? '0 : q_data;
    assign ram_re    = q_pop && !q_op.is_write && q_op.hit;

    always_comb begin
        rd_valid_next = rd_valid_reg;
        if (q_pop && !q_op.is_write) begin
            rd_valid_next = 1'b1;
        end else if (rd_advance) begin
            rd_valid_next = 1'b0;
        end
    end

    dmxw_ram #(
        .WIDTH (BW),
        .DEPTH (WINDOW),
        .AW    (IDXW)
    ) u_store (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (q_index),
        .rdata (ram_rdata)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clearing_reg <= 1'b1;
            clr_addr_reg <= '0;
            rd_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            rd_valid_reg <= rd_valid_next;
            if (clearing_reg) begin
                clr_addr_reg <= clr_addr_reg + IDXW'(1);
                if (clr_addr_reg == IDXW'(WINDOW - 1)) begin
                    clearing_reg <= 1'b0;
                end
            end
            if (rd_advance) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (q_pop && !q_op.is_write) begin
            rd_hit_reg <= q_op.hit;
        end
        if (rd_advance) begin
            m_value_reg    <= rd_hit_reg ? ram_rdata : '0;
            m_in_range_reg <= rd_hit_reg;
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_read_value = m_value_reg;
    assign m_in_range   = m_in_range_reg;

endmodule

// File: bench/tb_dmx512_window_receiver.sv
// ----------------------------------------------------------------------------
// tb_dmx512_window_receiver
// Self-checking bench for the DMX512 window receiver. Byte streams (breaks,
// start codes, slot data) and relative/absolute read requests are driven
// with random gaps on both channels. A local copy of the receive phase,
// slot counter and window store predicts every read result, and each
// result is checked in order.
// ----------------------------------------------------------------------------
module tb_dmx512_window_receiver;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int WINDOW        = 16;
    localparam int STALL_LIMIT   = 3000;
    localparam int SETTLE_CYCLES = 8;
    localparam logic [dmxw_pkg::CMD_W-1:0] CMD_UNUSED = 2'd3;

    typedef enum logic [1:0] {RX_IDLE = 2'd0, RX_BREAK = 2'd1, RX_DATA = 2'd2} rx_phase_t;

    typedef struct packed {
        logic [dmxw_pkg::BYTE_W-1:0] value;
        logic                        in_range;
    } readback_t;

    logic                        aclk          = 1'b0;
    logic                        aresetn       = 1'b0;
    logic                        s_valid       = 1'b0;
    logic                        s_ready;
    logic [dmxw_pkg::CMD_W-1:0]  s_command     = dmxw_pkg::CMD_BYTE;
    logic [dmxw_pkg::BYTE_W-1:0] s_rx_byte     = '0;
    logic                        s_frame_error = 1'b0;
    logic [dmxw_pkg::SLOT_W-1:0] s_channel     = '0;
    logic                        m_valid;
    logic                        m_ready       = 1'b0;
    logic [dmxw_pkg::BYTE_W-1:0] m_read_value;
    logic                        m_in_range;
    logic                        cfg_valid     = 1'b0;
    logic                        cfg_ready;
    logic [dmxw_pkg::SLOT_W-1:0] cfg_data      = '0;

    // local copy of the receiver state
    rx_phase_t                   rx_phase;
    logic [dmxw_pkg::SLOT_W-1:0] rx_slot;
    logic [dmxw_pkg::SLOT_W-1:0] rx_start;
    logic [dmxw_pkg::BYTE_W-1:0] slot_copy [WINDOW];

    readback_t          pending_reads [$];

    int send_idle_pct     = 0;
    int recv_idle_pct     = 0;
    int ready_hold_cycles = 0;
    int items_sent        = 0;
    int reads_checked     = 0;
    int cfg_writes        = 0;
    int errors            = 0;

    dmx512_window_receiver #(.WINDOW(WINDOW)) uut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_command     (s_command),
        .s_rx_byte     (s_rx_byte),
        .s_frame_error (s_frame_error),
        .s_channel     (s_channel),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_read_value  (m_read_value),
        .m_in_range    (m_in_range),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data)
    );

    initial begin
        forever #4 aclk = ~aclk;
    end

    function automatic void reset_receiver_copy();
        rx_start = 10'd1;
        rx_phase = RX_IDLE;
        rx_slot  = '0;
        foreach (slot_copy[i]) slot_copy[i] = '0;
    endfunction

    function automatic void advance_receiver(logic [dmxw_pkg::BYTE_W-1:0] data, logic brk);
        int win_end;
        win_end = int'(rx_start) + WINDOW;
        if (brk) begin
            rx_phase = RX_BREAK;
            rx_slot  = '0;
            return;
        end
        if (rx_phase == RX_BREAK) begin
            if (data == 8'h00) begin
                rx_phase = RX_DATA;
                rx_slot  = 10'd1;
            end else begin
                rx_phase = RX_IDLE;
            end
            return;
        end
        if (rx_phase != RX_DATA) return;
        if (rx_slot >= rx_start && int'(rx_slot) < win_end)
            slot_copy[rx_slot - rx_start] = data;
        if (int'(rx_slot) >= win_end) rx_phase = RX_IDLE;
        // hold at the top instead of wrapping
        if (rx_slot != dmxw_pkg::COUNTER_MAX) rx_slot = rx_slot + 10'd1;
    endfunction

    function automatic readback_t read_window_slot(logic [dmxw_pkg::CMD_W-1:0] cmd,
                                                   logic [dmxw_pkg::SLOT_W-1:0] chan);
        readback_t r;
        r = '0;
        if (cmd == dmxw_pkg::CMD_READ_REL) begin
            if (chan < WINDOW) begin
                r.value    = slot_copy[chan];
                r.in_range = 1'b1;
            end
        end else if (chan >= 1 && chan <= dmxw_pkg::DMX_SLOTS && chan >= rx_start &&
                     int'(chan) - int'(rx_start) < WINDOW) begin
            r.value    = slot_copy[chan - rx_start];
            r.in_range = 1'b1;
        end
        return r;
    endfunction

    task automatic send_item(input logic [dmxw_pkg::CMD_W-1:0] cmd,
                             input logic [dmxw_pkg::BYTE_W-1:0] data,
                             input logic brk, input logic [dmxw_pkg::SLOT_W-1:0] chan);
        @(negedge aclk);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid       <= 1'b1;
        s_command     <= cmd;
        s_rx_byte     <= data;
        s_frame_error <= brk;
        s_channel     <= chan;
        do @(posedge aclk); while (s_ready !== 1'b1);
        case (cmd)
            dmxw_pkg::CMD_BYTE: advance_receiver(data, brk);
            dmxw_pkg::CMD_READ_REL, dmxw_pkg::CMD_READ_ABS:
                pending_reads.push_back(read_window_slot(cmd, chan));
            default: ;
        endcase
        items_sent++;
    endtask

    task automatic random_read();
        logic [dmxw_pkg::CMD_W-1:0]  cmd;
        logic [dmxw_pkg::SLOT_W-1:0] chan;
        cmd = $urandom_range(1) ? dmxw_pkg::CMD_READ_ABS : dmxw_pkg::CMD_READ_REL;
        if ($urandom_range(9) < 7)
            chan = (cmd == dmxw_pkg::CMD_READ_REL)
                   ? 10'($urandom_range(WINDOW + 3))
                   : 10'(int'(rx_start) - 2 + $urandom_range(WINDOW + 4));
        else
            chan = 10'($urandom);
        send_item(cmd, 8'($urandom), 1'($urandom), chan);
    endtask

    // drop valid, wait for every outstanding read, then let the pipe empty
    task automatic quiesce();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (pending_reads.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_start_address(input logic [dmxw_pkg::SLOT_W-1:0] addr);
        quiesce();
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_data  <= addr;
        do @(posedge aclk); while (cfg_ready !== 1'b1);
        rx_start = addr;
        cfg_writes++;
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    task automatic test_reset_reads();
        send_item(dmxw_pkg::CMD_READ_REL, 8'h00, 1'b0, 10'd0);
        send_item(dmxw_pkg::CMD_READ_REL, 8'hFF, 1'b0, 10'd15);
        send_item(dmxw_pkg::CMD_READ_REL, 8'h00, 1'b0, 10'd16);
        send_item(dmxw_pkg::CMD_READ_REL, 8'h00, 1'b1, 10'd1023);
        send_item(dmxw_pkg::CMD_READ_ABS, 8'h00, 1'b0, 10'd0);
        send_item(dmxw_pkg::CMD_READ_ABS, 8'h00, 1'b0, 10'd1);
        send_item(dmxw_pkg::CMD_READ_ABS, 8'h00, 1'b0, 10'd17);
        send_item(CMD_UNUSED,             8'hFF, 1'b1, 10'd1023);
    endtask

    task automatic test_frame_capture();
        // byte before any break is dropped
        send_item(dmxw_pkg::CMD_BYTE, 8'h3C, 1'b0, 10'd0);
        send_item(dmxw_pkg::CMD_BYTE, 8'h55, 1'b1, 10'd0);
        send_item(dmxw_pkg::CMD_BYTE, 8'h00, 1'b0, 10'd0);
        send_item(dmxw_pkg::CMD_BYTE, 8'hFF, 1'b0, 10'd0);
        send_item(dmxw_pkg::CMD_BYTE, 8'h00, 1'b0, 10'd0);
        for (int k = 3; k <= WINDOW + 2; k++)
            send_item(dmxw_pkg::CMD_BYTE, 8'(k * 17), 1'b0, 10'd0);
        send_item(dmxw_pkg::CMD_READ_REL, 8'h00, 1'b0, 10'd0);
        send_item(dmxw_pkg::CMD_READ_REL, 8'h00, 1'b1, 10'd15);
        send_item(dmxw_pkg::CMD_READ_ABS, 8'h00, 1'b0, 10'd16);
        send_item(dmxw_pkg::CMD_READ_ABS, 8'h00, 1'b0, 10'd512);
    endtask

    task automatic test_start_codes();
        send_item(dmxw_pkg::CMD_BYTE, 8'h00, 1'b1, 10'd0);
        send_item(dmxw_pkg::CMD_BYTE, 8'h00, 1'b0, 10'd0);
        send_item(dmxw_pkg::CMD_BYTE, 8'h11, 1'b0, 10'd0);
        // break in the middle of a frame, then a non-zero start code
        send_item(dmxw_pkg::CMD_BYTE, 8'hAA, 1'b1, 10'd0);
        send_item(dmxw_pkg::CMD_BYTE, 8'h00, 1'b1, 10'd0);
        send_item(dmxw_pkg::CMD_BYTE, 8'hCC, 1'b0, 10'd0);
        send_item(dmxw_pkg::CMD_BYTE, 8'h22, 1'b0, 10'd0);
        send_item(dmxw_pkg::CMD_READ_REL, 8'h00, 1'b0, 10'd0);
        send_item(dmxw_pkg::CMD_READ_REL, 8'h00, 1'b0, 10'd1);
    endtask

    task automatic test_config_extremes();
        logic [dmxw_pkg::SLOT_W-1:0] extremes [5] =
            '{10'd0, 10'd497, 10'd505, 10'd512, 10'd1023};
        foreach (extremes[i]) begin
            write_start_address(extremes[i]);
            send_item(dmxw_pkg::CMD_READ_ABS, 8'h00, 1'b0, extremes[i] - 10'd1);
            send_item(dmxw_pkg::CMD_READ_ABS, 8'h00, 1'b0, extremes[i]);
            send_item(dmxw_pkg::CMD_READ_ABS, 8'h00, 1'b0, extremes[i] + 10'd7);
            send_item(dmxw_pkg::CMD_READ_ABS, 8'h00, 1'b0, extremes[i] + 10'(WINDOW - 1));
            send_item(dmxw_pkg::CMD_READ_ABS, 8'h00, 1'b0, extremes[i] + 10'(WINDOW));
        end
    endtask

    task automatic random_traffic(input int n_items);
        int target;
        int action;
        int span;
        target = items_sent + n_items;
        while (items_sent < target) begin
            action = $urandom_range(99);
            if (action < 65) begin
                send_item(dmxw_pkg::CMD_BYTE, 8'($urandom), 1'b1, 10'($urandom));
                send_item(dmxw_pkg::CMD_BYTE,
                          ($urandom_range(7) == 0) ? 8'($urandom_range(255, 1)) : 8'h00,
                          1'b0, 10'($urandom));
                span = $urandom_range(int'(rx_start) + WINDOW + 3);
                for (int k = 0; k < span; k++) begin
                    if ($urandom_range(4) == 0) random_read();
                    send_item(dmxw_pkg::CMD_BYTE, 8'($urandom), 1'b0, 10'($urandom));
                end
            end else if (action < 85) begin
                repeat ($urandom_range(8, 1)) random_read();
            end else begin
                send_item(2'($urandom), 8'($urandom), 1'($urandom), 10'($urandom));
            end
        end
    endtask

    task automatic test_random_traffic();
        write_start_address(10'($urandom_range(24, 1)));
        send_idle_pct = 26;
        recv_idle_pct = 61;
        random_traffic(180);
        write_start_address(10'd0);
        send_idle_pct = 61;
        recv_idle_pct = 26;
        random_traffic(180);
        write_start_address(10'd8);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        random_traffic(180);
    endtask

    task automatic test_backpressure();
        quiesce();
        ready_hold_cycles = 300;
        repeat (40) random_read();
    endtask

    always @(negedge aclk) begin
        if (ready_hold_cycles > 0) begin
            m_ready <= 1'b0;
            ready_hold_cycles--;
        end else begin
            m_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    always @(posedge aclk) begin : check_results
        readback_t want;
        if (aresetn && m_valid === 1'b1 && m_ready === 1'b1) begin
            if (pending_reads.size() == 0) begin
                $display("%0t: result with no read request: value=%02h in_range=%0b",
                         $time, m_read_value, m_in_range);
                errors++;
            end else begin
                want = pending_reads.pop_front();
                if (m_read_value !== want.value) begin
                    $display("%0t: read_value mismatch: expected %02h, got %02h",
                             $time, want.value, m_read_value);
                    errors++;
                end
                if (m_in_range !== want.in_range) begin
                    $display("%0t: in_range mismatch: expected %0b, got %0b",
                             $time, want.in_range, m_in_range);
                    errors++;
                end
                reads_checked++;
            end
        end
    end

    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT) begin
            @(posedge aclk);
            if ((s_valid === 1'b1 && s_ready === 1'b1) || (m_valid === 1'b1 && m_ready === 1'b1) ||
                (cfg_valid === 1'b1 && cfg_ready === 1'b1))
                quiet = 0;
            else
                quiet++;
        end
        $display("%0t: no handshake for %0d cycles", $time, STALL_LIMIT);
        $display("Regression FAIL");
        $finish;
    end

    initial begin
        reset_receiver_copy();
        repeat (6) @(negedge aclk);
        aresetn <= 1'b1;
        test_reset_reads();
        test_frame_capture();
        test_start_codes();
        test_config_extremes();
        test_random_traffic();
        test_backpressure();
        quiesce();
        if (pending_reads.size() != 0) begin
            $display("%0t: %0d read results never arrived", $time, pending_reads.size());
            errors++;
        end
        $display("Sent %0d requests, checked %0d read results over %0d start addresses,",
                 items_sent, reads_checked, cfg_writes);
        $display("incl. address extremes, start codes, breaks and a long output stall.");
        if (errors == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

// File: dmx512_window_receiver.f
rtl/dmxw_pkg.sv
rtl/dmxw_ram.sv
rtl/dmxw_front.sv
rtl/dmxw_queue.sv
rtl/dmxw_back.sv
rtl/dmx512_window_receiver.sv
bench/tb_dmx512_window_receiver.sv
